### sv/dtdi_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the bit-delay function of the time deinterleaver.
// Depends on nothing; every other file refers to it by scoped names.
package dtdi_pkg;

   localparam int DEPTH_FRAMES        = 16;
   localparam int ROW_W               = 4;
   localparam int BYTE_W              = 8;
   localparam int CFG_W               = 14;
   localparam int MAX_FRAME_BYTES_DEF = 8192;

   localparam logic [CFG_W-1:0] FRAME_BYTES_RST = 14'd6912;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } ctl_state_type;

   // Per-request control that travels alongside the memory read.
   typedef struct packed {
      logic [ROW_W-1:0] head;
      logic             half;
      logic             last;
   } item_ctl_type;

   // Delay in frames of bit k of a byte pair (k = 0 is the even byte MSB).
   function automatic logic [ROW_W-1:0] bit_delay(input logic [ROW_W-1:0] k);
      bit_delay = {k[0], k[1], k[2], k[3]};
   endfunction

endpackage

### sv/dab_time_deinterleaver.sv
`timescale 1ns / 1ps
// Convolutional time deinterleaver over 16 frames, one byte per request.
// Requests (req_valid / req_stall / req_data_byte) carry the bytes of the
// interleaved frames in order; each yields one response (rsp_out_byte,
// rsp_frame_end) holding the deinterleaved byte at the same frame position.
// Frame size is set through csr_wr_en / csr_wr_data (bit 0 ignored, clamped to
// 2 .. MAX_FRAME_BYTES); write it only while no request is in flight.
// Pipeline: two register stages, the read stage (bank reads and s1 registers)
// and the response register, which holds the read stage while it is stalled.
// Throughput: one request per cycle while req_stall is low; the 16 frame
// rows sit in 16 banks, so the head-row write and delayed-row reads coincide.
// Reset: a clearing sweep writes zeros to every position of every row, one
// position per cycle across all banks; req_stall stays high meanwhile. Frame
// size returns to 6912 bytes.
// Receiver stall: the response register holds; one more request may enter
// the read stage, after which req_stall rises until the response is taken.
// Depends on dtdi_pkg, dtdi_ctrl, dtdi_bank and dtdi_outstage.
module dab_time_deinterleaver #(
   parameter int MAX_FRAME_BYTES = dtdi_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [dtdi_pkg::CFG_W-1:0]        csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dtdi_pkg::BYTE_W-1:0]       req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dtdi_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                              rsp_frame_end
);

   localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);

   logic                                                   accept;
   logic                                                   can_take;
   dtdi_pkg::item_ctl_type                                 item_ctl;
   logic [ADDR_W-1:0]                                      mem_addr;
   logic [dtdi_pkg::DEPTH_FRAMES-1:0]                      mem_wr_en;
   logic                                                   mem_rd_en;
   logic [dtdi_pkg::BYTE_W-1:0]                            mem_wr_data;
   logic [dtdi_pkg::DEPTH_FRAMES-1:0][dtdi_pkg::BYTE_W-1:0] rd_data;

   // Position, head row, frame size and the reset sweep.
   dtdi_ctrl #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .ADDR_W          (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .can_take      (can_take),
      .req_stall     (req_stall),
      .accept        (accept),
      .item_ctl      (item_ctl),
      .mem_addr      (mem_addr),
      .mem_wr_en     (mem_wr_en),
      .mem_rd_en     (mem_rd_en),
      .mem_wr_data   (mem_wr_data)
   );

   // One bank per frame row; all share the position address. Consecutive
   // requests never hit the same position, so no forwarding is needed.
   for (genvar r = 0; r < dtdi_pkg::DEPTH_FRAMES; r++) begin : g_row
      dtdi_bank #(
         .DEPTH  (MAX_FRAME_BYTES),
         .ADDR_W (ADDR_W)
      ) u_bank (
         .clock   (clock),
         .wr_en   (mem_wr_en[r]),
         .rd_en   (mem_rd_en),
         .addr    (mem_addr),
         .wr_data (mem_wr_data),
         .rd_data (rd_data[r])
      );
   end

   // Bit selection and the response register.
   dtdi_outstage u_out (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .item_ctl      (item_ctl),
      .req_data_byte (req_data_byte),
      .rd_data       (rd_data),
      .rsp_stall     (rsp_stall),
      .can_take      (can_take),
      .rsp_valid     (rsp_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

### sv/dtdi_bank.sv
`timescale 1ns / 1ps
// One frame row of the deinterleaver store: a single-port synchronous RAM
// with registered read data. Depends on dtdi_pkg.
module dtdi_bank #(
   parameter int DEPTH  = dtdi_pkg::MAX_FRAME_BYTES_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           addr,
   input  logic [dtdi_pkg::BYTE_W-1:0] wr_data,
   output logic [dtdi_pkg::BYTE_W-1:0] rd_data
);

   logic [dtdi_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [dtdi_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dtdi_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the deinterleaver: frame size register, byte position, head row,
// clearing sweep and memory access generation. Depends on dtdi_pkg.
module dtdi_ctrl #(
   parameter int MAX_FRAME_BYTES = dtdi_pkg::MAX_FRAME_BYTES_DEF,
   parameter int ADDR_W          = $clog2(MAX_FRAME_BYTES)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [dtdi_pkg::CFG_W-1:0]           csr_wr_data,
   input  logic                                 req_valid,
   input  logic [dtdi_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic                                 can_take,
   output logic                                 req_stall,
   output logic                                 accept,
   output dtdi_pkg::item_ctl_type               item_ctl,
   output logic [ADDR_W-1:0]                    mem_addr,
   output logic [dtdi_pkg::DEPTH_FRAMES-1:0]    mem_wr_en,
   output logic                                 mem_rd_en,
   output logic [dtdi_pkg::BYTE_W-1:0]          mem_wr_data
);

   localparam int SIZE_W = ($clog2(MAX_FRAME_BYTES + 1) > dtdi_pkg::CFG_W) ?
                           $clog2(MAX_FRAME_BYTES + 1) : dtdi_pkg::CFG_W;
   localparam int TOP_SIZE = MAX_FRAME_BYTES - (MAX_FRAME_BYTES % 2);
   localparam logic [SIZE_W-1:0] TOP_VAL  = SIZE_W'(TOP_SIZE);
   localparam logic [SIZE_W-1:0] MIN_VAL  = SIZE_W'(2);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_FRAME_BYTES - 1);

   // Clamp the register value to an even size in [2, TOP_SIZE], minus one.
   function automatic logic [SIZE_W-1:0] size_m1(input logic [dtdi_pkg::CFG_W-1:0] v);
      logic [SIZE_W-1:0] fs;
      fs = SIZE_W'({v[dtdi_pkg::CFG_W-1:1], 1'b0});
      if (fs < MIN_VAL) begin
         fs = MIN_VAL;
      end else if (fs > TOP_VAL) begin
         fs = TOP_VAL;
      end
      size_m1 = fs - SIZE_W'(1);
   endfunction

   dtdi_pkg::ctl_state_type state_ff, state_in;
   logic [ADDR_W-1:0]            clr_addr_ff, clr_addr_in;
   logic [SIZE_W-1:0]            size_m1_ff;
   logic [ADDR_W-1:0]            pos_ff;
   logic [dtdi_pkg::ROW_W-1:0]   head_ff;
   logic [ADDR_W-1:0]            pos_eff;
   logic                         first;
   logic                         last;
   logic [dtdi_pkg::ROW_W-1:0]   head_new;
   logic                         running;

   // Position left over from a larger frame size starts a new frame.
   always_comb begin
      pos_eff  = (SIZE_W'(pos_ff) > size_m1_ff) ? '0 : pos_ff;
      first    = (pos_eff == '0);
      last     = (SIZE_W'(pos_eff) == size_m1_ff);
      head_new = first ? head_ff + dtdi_pkg::ROW_W'(1) : head_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dtdi_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      running     = 1'b0;
      unique case (state_ff)
         dtdi_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in    = dtdi_pkg::ST_RUN;
               clr_addr_in = '0;
            end
         end
         dtdi_pkg::ST_RUN: begin
            running = 1'b1;
         end
         default: begin
            state_in = dtdi_pkg::ST_CLEAR;
         end
      endcase
   end

   assign accept    = req_valid && running && can_take;
   assign req_stall = !(running && can_take);

   // Sweep zeros through every row while clearing; otherwise, for an accepted
   // request, write the head row and read all rows at the current position.
   always_comb begin
      mem_wr_en   = '0;
      mem_rd_en   = 1'b0;
      mem_wr_data = req_data_byte;
      mem_addr    = pos_eff;
      if (!running) begin
         mem_addr    = clr_addr_ff;
         mem_wr_en   = '1;
         mem_wr_data = '0;
      end else if (accept) begin
         mem_wr_en[head_new] = 1'b1;
         mem_rd_en           = 1'b1;
      end
   end

   assign item_ctl.head = head_new;
   assign item_ctl.half = pos_eff[0];
   assign item_ctl.last = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_m1_ff <= size_m1(dtdi_pkg::FRAME_BYTES_RST);
         pos_ff     <= '0;
         head_ff    <= dtdi_pkg::ROW_W'(dtdi_pkg::DEPTH_FRAMES - 1);
      end else begin
         if (csr_wr_en) begin
            size_m1_ff <= size_m1(csr_wr_data);
         end
         if (accept) begin
            head_ff <= head_new;
            pos_ff  <= last ? '0 : pos_eff + ADDR_W'(1);
         end
      end
   end

endmodule

### sv/dtdi_outstage.sv
`timescale 1ns / 1ps
// Read-data stage and output register: picks each result bit from its delayed
// row and holds the result for the receiver. Depends on dtdi_pkg.
module dtdi_outstage (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  accept,
   input  dtdi_pkg::item_ctl_type                                item_ctl,
   input  logic [dtdi_pkg::BYTE_W-1:0]                           req_data_byte,
   input  logic [dtdi_pkg::DEPTH_FRAMES-1:0][dtdi_pkg::BYTE_W-1:0] rd_data,
   input  logic                                                  rsp_stall,
   output logic                                                  can_take,
   output logic                                                  rsp_valid,
   output logic [dtdi_pkg::BYTE_W-1:0]                           rsp_out_byte,
   output logic                                                  rsp_frame_end
);

   logic                              s1_valid_ff;
   dtdi_pkg::item_ctl_type            s1_ctl_ff;
   logic [dtdi_pkg::BYTE_W-1:0]       s1_byte_ff;
   logic                              rsp_valid_ff;
   logic [dtdi_pkg::BYTE_W-1:0]       rsp_byte_ff;
   logic                              rsp_end_ff;
   logic                              out_free;
   logic [dtdi_pkg::BYTE_W-1:0]       assembled;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_take = !s1_valid_ff || out_free;

   // Bit b (MSB first) comes from the row bit_delay frames behind the head;
   // zero delay is the request byte itself, whose row write is still in flight.
   always_comb begin
      logic [dtdi_pkg::ROW_W-1:0] d;
      logic [dtdi_pkg::ROW_W-1:0] row;
      for (int b = 0; b < dtdi_pkg::BYTE_W; b++) begin
         d   = dtdi_pkg::bit_delay({s1_ctl_ff.half, 3'(b)});
         row = s1_ctl_ff.head - d;
         if (d == '0) begin
            assembled[dtdi_pkg::BYTE_W-1-b] = s1_byte_ff[dtdi_pkg::BYTE_W-1-b];
         end else begin
            assembled[dtdi_pkg::BYTE_W-1-b] = rd_data[row][dtdi_pkg::BYTE_W-1-b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (out_free) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff  <= item_ctl;
         s1_byte_ff <= req_data_byte;
      end
      if (out_free && s1_valid_ff) begin
         rsp_byte_ff <= assembled;
         rsp_end_ff  <= s1_ctl_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_frame_end = rsp_end_ff;

endmodule
